// ===== rtl/core/afc_pkg.sv =====
// Shared types and constants for the box versus frustum cull test.
`timescale 1ns / 1ps
`default_nettype none

package afc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NORM_W     = 16;
  localparam int FRAC_BITS  = 14;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 3;
  localparam int VIS_W      = 2;
  localparam int OUT_DATA_W = 8;

  localparam logic [VIS_W-1:0] VIS_OUTSIDE = 2'd0;
  localparam logic [VIS_W-1:0] VIS_PARTIAL = 2'd1;
  localparam logic [VIS_W-1:0] VIS_INSIDE  = 2'd2;

  typedef struct packed {
    logic vld;
    logic outside;
    logic partial;
  } cull_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/afc_cell.sv =====
// One plane cell: holds a plane, tests the passing box in two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none

module afc_cell
  import afc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int PLANE_IDX   = 0
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        adv,
  input  wire                        cfg_wr_en,
  input  wire [CFG_ADDR_W-1:0]       cfg_addr,
  input  wire [CFG_DATA_W-1:0]       cfg_wdata,
  input  wire [6*COORD_WIDTH-1:0]    box_i,
  input  cull_flags_t                flags_i,
  output logic [6*COORD_WIDTH-1:0]   box_o,
  output cull_flags_t                flags_o
);

  localparam int PROD_W = NORM_W + COORD_WIDTH;
  localparam int DTERM_W = NORM_W + FRAC_BITS;
  localparam int DIST_W = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;

  logic [CFG_DATA_W-1:0] plane_r;

  logic signed [NORM_W-1:0] norm [3];
  logic signed [NORM_W-1:0] ofs;

  // stage A: products
  logic signed [PROD_W-1:0]      pfar_nxt  [3];
  logic signed [PROD_W-1:0]      pnear_nxt [3];
  logic signed [PROD_W-1:0]      pfar_r    [3];
  logic signed [PROD_W-1:0]      pnear_r   [3];
  logic [6*COORD_WIDTH-1:0]      box_a_r;
  cull_flags_t                   flags_a_r;

  // stage B: sums and sign tests
  logic signed [DIST_W-1:0]      dterm;
  logic signed [DIST_W-1:0]      dist_far;
  logic signed [DIST_W-1:0]      dist_near;
  cull_flags_t                   flags_b_nxt;
  cull_flags_t                   flags_b_r;
  logic [6*COORD_WIDTH-1:0]      box_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_wr_en && (cfg_addr == CFG_ADDR_W'(PLANE_IDX))) begin
      plane_r <= cfg_wdata;
    end
  end

  assign norm[0] = plane_r[63:48];
  assign norm[1] = plane_r[47:32];
  assign norm[2] = plane_r[31:16];
  assign ofs     = plane_r[15:0];

  always_comb begin
    logic signed [COORD_WIDTH-1:0] lo;
    logic signed [COORD_WIDTH-1:0] hi;
    for (int k = 0; k < 3; k++) begin
      lo = box_i[k*COORD_WIDTH +: COORD_WIDTH];
      hi = box_i[(k+3)*COORD_WIDTH +: COORD_WIDTH];
      if (norm[k][NORM_W-1]) begin
        pfar_nxt[k]  = norm[k] * lo;
        pnear_nxt[k] = norm[k] * hi;
      end else begin
        pfar_nxt[k]  = norm[k] * hi;
        pnear_nxt[k] = norm[k] * lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_a_r <= '0;
    end else if (adv) begin
      flags_a_r <= flags_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box_a_r <= box_i;
      for (int k = 0; k < 3; k++) begin
        pfar_r[k]  <= pfar_nxt[k];
        pnear_r[k] <= pnear_nxt[k];
      end
    end
  end

  assign dterm = {{(DIST_W-DTERM_W){ofs[NORM_W-1]}}, ofs, {FRAC_BITS{1'b0}}};

  always_comb begin
    dist_far  = DIST_W'(pfar_r[0]) + DIST_W'(pfar_r[1]) + DIST_W'(pfar_r[2]) + dterm;
    dist_near = DIST_W'(pnear_r[0]) + DIST_W'(pnear_r[1]) + DIST_W'(pnear_r[2]) + dterm;
    flags_b_nxt.vld     = flags_a_r.vld;
    flags_b_nxt.outside = flags_a_r.outside | dist_far[DIST_W-1];
    flags_b_nxt.partial = flags_a_r.partial | dist_near[DIST_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_b_r <= '0;
    end else if (adv) begin
      flags_b_r <= flags_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box_b_r <= box_a_r;
    end
  end

  assign box_o   = box_b_r;
  assign flags_o = flags_b_r;

endmodule

`default_nettype wire

// ===== rtl/core/aabb_frustum_cull_test_core.sv =====
// Top level: chain of six plane cells classifying boxes against a frustum.
`timescale 1ns / 1ps
`default_nettype none

// Classifies one axis-aligned box per transaction against six frustum planes
// (right, left, top, bottom, far, near) loaded through the cfg port at indices
// 0 to 5. A new box is accepted every cycle while the chain is not stalled. The chain
// holds 12 register stages, two pipeline stages (products, then sum and sign test)
// in each of the six plane cells. The whole chain stalls together while a result
// waits on out_tready. visibility: 0 outside, 1 partial, 2 inside. Planes are reset
// to zero, which classifies every box as inside. Write planes only while idle.
module aabb_frustum_cull_test_core
  import afc_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z, zero padding
  input  wire [((6*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // visibility, zero padding
  output logic [OUT_DATA_W-1:0]                 out_tdata,
  input  wire                                   cfg_wr_en,
  input  wire [CFG_ADDR_W-1:0]                  cfg_addr,
  input  wire [CFG_DATA_W-1:0]                  cfg_wdata
);

  localparam int BOX_W = 6*COORD_WIDTH;

  logic [BOX_W-1:0] box_chain   [NUM_PLANES+1];
  cull_flags_t      flags_chain [NUM_PLANES+1];
  logic             adv;
  logic [VIS_W-1:0] vis;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  assign box_chain[0]           = in_tdata[BOX_W-1:0];
  assign flags_chain[0].vld     = in_tvalid;
  assign flags_chain[0].outside = 1'b0;
  assign flags_chain[0].partial = 1'b0;

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    afc_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .PLANE_IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .cfg_wr_en (cfg_wr_en),
      .cfg_addr  (cfg_addr),
      .cfg_wdata (cfg_wdata),
      .box_i     (box_chain[i]),
      .flags_i   (flags_chain[i]),
      .box_o     (box_chain[i+1]),
      .flags_o   (flags_chain[i+1])
    );
  end

  always_comb begin
    if (flags_chain[NUM_PLANES].outside) begin
      vis = VIS_OUTSIDE;
    end else if (flags_chain[NUM_PLANES].partial) begin
      vis = VIS_PARTIAL;
    end else begin
      vis = VIS_INSIDE;
    end
  end

  assign out_tvalid = flags_chain[NUM_PLANES].vld;
  assign out_tdata  = {{(OUT_DATA_W-VIS_W){1'b0}}, vis};

endmodule

`default_nettype wire

// ===== rtl/core/afc_checker.sv =====
// Port-level checker for the cull test core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module afc_checker
  import afc_pkg::*;
(
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_tready,
  input wire                                 out_tvalid,
  input wire                                 out_tready,
  input wire [OUT_DATA_W-1:0]                out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_vis_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == {{(OUT_DATA_W-VIS_W){1'b0}}, VIS_OUTSIDE}) ||
                   (out_tdata == {{(OUT_DATA_W-VIS_W){1'b0}}, VIS_PARTIAL}) ||
                   (out_tdata == {{(OUT_DATA_W-VIS_W){1'b0}}, VIS_INSIDE}))
    else $error("bad visibility code");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind aabb_frustum_cull_test_core afc_checker u_afc_checker (.*);

`default_nettype wire
